// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the coloring search RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clock, disabled during reset.
`define GMCS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, disabled during reset.
`define GMCS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/gmcs_pkg.sv =====
// Package: fixed field widths, register indexes, register reset values and lane control type.
package gmcs_pkg;

   // Fixed payload and register widths
   localparam int ROW_W          = 4;
   localparam int MASK_W         = 16;
   localparam int NUM_COLORS_W   = 4;
   localparam int NUM_VERTICES_W = 5;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 5;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_COLORS   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_VERTICES = 1'b1;

   // Register reset values
   localparam logic [NUM_COLORS_W-1:0]   NUM_COLORS_RST   = 4'd3;
   localparam logic [NUM_VERTICES_W-1:0] NUM_VERTICES_RST = 5'd16;

   // Controls from the sequencer to every lane
   typedef struct packed {
      logic clear;    // wipe the stored color at search start
      logic capture;  // register the lane compare results
      logic load;     // write a color into the addressed lane
   } lane_ctl_type;

endpackage

// ===== hw/rtl/gmcs_lane.sv =====
// One vertex lane: holds that vertex's color and flags it when it blocks the current vertex.
module gmcs_lane #(
   parameter int LANE_ID = 0,
   parameter int IDX_W   = 4,
   parameter int VCNT_W  = 5,
   parameter int COLOR_W = 4,
   parameter int NCOLORS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gmcs_pkg::lane_ctl_type      ctl,
   input  logic [IDX_W-1:0]            load_target,
   input  logic [COLOR_W-1:0]          load_color,
   input  logic [VCNT_W-1:0]           cur_vertex,
   input  logic [VCNT_W-1:0]           vertex_count,
   input  logic                        adj_bit,
   output logic [NCOLORS-1:0]          used_ff,
   output logic [COLOR_W-1:0]          cur_color_ff
);

   logic [COLOR_W-1:0] color_ff;
   logic               is_current;
   logic               blocks;
   logic [NCOLORS-1:0] used_in;

   assign is_current = (cur_vertex == VCNT_W'(LANE_ID));
   // A neighbor in range, other than the vertex under test, with a real color
   assign blocks = adj_bit && (VCNT_W'(LANE_ID) < vertex_count) && !is_current
                   && (color_ff != '0);

   // One-hot of the blocked color; bit k stands for color k+1
   always_comb begin
      used_in = '0;
      for (int k = 0; k < NCOLORS; k++) begin
         if (blocks && (color_ff == COLOR_W'(k + 1))) begin
            used_in[k] = 1'b1;
         end
      end
   end

   // Color store and registered compare results
   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= '0;
      end else if (ctl.clear) begin
         color_ff <= '0;
      end else if (ctl.load && (load_target == IDX_W'(LANE_ID))) begin
         color_ff <= load_color;
      end
      if (ctl.capture) begin
         used_ff      <= used_in;
         cur_color_ff <= is_current ? color_ff : '0;
      end
   end

endmodule

// ===== hw/rtl/gmcs_merge.sv =====
// Merge stage: combines lane results and picks the next color to try.
module gmcs_merge #(
   parameter int NLANES  = 16,
   parameter int COLOR_W = 4,
   parameter int NCOLORS = 8
) (
   input  logic [NLANES-1:0][NCOLORS-1:0] used_in,
   input  logic [NLANES-1:0][COLOR_W-1:0] cur_in,
   input  logic [COLOR_W-1:0]             color_limit,
   output logic                           found,
   output logic [COLOR_W-1:0]             pick_color
);

   logic [NCOLORS-1:0] used_all;
   logic [COLOR_W-1:0] cur_color;

   // OR across lanes: blocked colors and the current vertex's old color
   always_comb begin
      used_all  = '0;
      cur_color = '0;
      for (int v = 0; v < NLANES; v++) begin
         used_all  = used_all | used_in[v];
         cur_color = cur_color | cur_in[v];
      end
   end

   // Lowest free color above the old one and within the limit
   always_comb begin
      found      = 1'b0;
      pick_color = '0;
      for (int k = NCOLORS - 1; k >= 0; k--) begin
         if (!used_all[k] && (COLOR_W'(k + 1) > cur_color)
             && (COLOR_W'(k + 1) <= color_limit)) begin
            found      = 1'b1;
            pick_color = COLOR_W'(k + 1);
         end
      end
   end

endmodule

// ===== hw/rtl/graph_m_coloring_search_unit.sv =====
// Top level: adjacency RAM, search sequencer, vertex lanes and merge stage.
// Graph m-coloring search unit. Adjacency rows are written one per cycle while no
// search runs, one row per transfer; a row transfer is taken even while a result
// waits, a last-row transfer waits until the previous result has left. The last
// row starts an exhaustive backtracking search. Each step of the search visits
// one vertex: adjacency RAM read, parallel lane compare against all stored
// colors, and the merge that picks the next color and moves the vertex pointer
// forward or back. The number of search steps before the yes/no result may grow
// exponentially with the vertex count. Config registers num_colors (index 0) and
// num_vertices (index 1) may only be written while the unit is idle; values above
// the parameters saturate.
`include "assert_macros.svh"

module graph_m_coloring_search_unit #(
   parameter int MAX_VERTICES = 16,
   parameter int MAX_COLORS   = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [gmcs_pkg::ROW_W-1:0]          req_row_vertex,
   input  logic [gmcs_pkg::MASK_W-1:0]         req_neighbor_mask,
   input  logic                                req_last_row,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_colorable,
   input  logic                                csr_write,
   input  logic [gmcs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gmcs_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int IDX_W   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int VCNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int COLOR_W = $clog2(MAX_COLORS + 1);

   typedef enum logic [1:0] {S_IDLE, S_FETCH, S_LANE, S_PICK} state_type;

   state_type                                 state_ff;
   logic [VCNT_W-1:0]                         u_ff;
   logic                                      rsp_valid_ff;
   logic                                      rsp_colorable_ff;
   logic [gmcs_pkg::NUM_COLORS_W-1:0]         num_colors_ff;
   logic [gmcs_pkg::NUM_VERTICES_W-1:0]       num_vertices_ff;
   logic [gmcs_pkg::MASK_W-1:0]               adj_mem [MAX_VERTICES];
   logic [gmcs_pkg::MASK_W-1:0]               row_rd_ff;

   logic                                      req_fire;
   logic                                      row_ok;
   logic [COLOR_W-1:0]                        nc_sat;
   logic [VCNT_W-1:0]                         nv_sat;
   gmcs_pkg::lane_ctl_type                    lane_ctl;
   logic [COLOR_W-1:0]                        load_color;
   logic [MAX_VERTICES-1:0][MAX_COLORS-1:0]   lane_used;
   logic [MAX_VERTICES-1:0][COLOR_W-1:0]      lane_cur;
   logic                                      pick_found;
   logic [COLOR_W-1:0]                        pick_color;

   // Handshake: no request is taken during a search; a last row also waits while a result is held and stalled
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall && req_last_row);
   assign req_fire  = req_valid && !req_stall;
   assign row_ok    = (32'(req_row_vertex) < 32'(MAX_VERTICES));
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_colorable = rsp_colorable_ff;

   // Saturated limits
   assign nc_sat = (32'(num_colors_ff) > 32'(MAX_COLORS)) ? COLOR_W'(MAX_COLORS)
                                                            : COLOR_W'(num_colors_ff);
   assign nv_sat = (32'(num_vertices_ff) > 32'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES)
                                                                : VCNT_W'(num_vertices_ff);

   // Adjacency RAM: written on row transfers, read once per search step
   always_ff @(posedge clock) begin
      if (req_fire && row_ok) begin
         adj_mem[IDX_W'(req_row_vertex)] <= req_neighbor_mask;
      end
      if (state_ff == S_FETCH) begin
         row_rd_ff <= adj_mem[u_ff[IDX_W-1:0]];
      end
   end

   // Lane controls
   always_comb begin
      lane_ctl.clear   = req_fire && req_last_row;
      lane_ctl.capture = (state_ff == S_LANE);
      lane_ctl.load    = (state_ff == S_PICK);
      load_color       = pick_found ? pick_color : '0;
   end

   // Vertex lanes
   for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_lane
      logic adj_bit;
      if (g < gmcs_pkg::MASK_W) begin : g_bit
         assign adj_bit = row_rd_ff[g];
      end else begin : g_nobit
         assign adj_bit = 1'b0;
      end
      gmcs_lane #(
         .LANE_ID (g),
         .IDX_W   (IDX_W),
         .VCNT_W  (VCNT_W),
         .COLOR_W (COLOR_W),
         .NCOLORS (MAX_COLORS)
      ) u_lane (
         .clock        (clock),
         .reset        (reset),
         .ctl          (lane_ctl),
         .load_target  (u_ff[IDX_W-1:0]),
         .load_color   (load_color),
         .cur_vertex   (u_ff),
         .vertex_count (nv_sat),
         .adj_bit      (adj_bit),
         .used_ff      (lane_used[g]),
         .cur_color_ff (lane_cur[g])
      );
   end

   // Merge of lane results
   gmcs_merge #(
      .NLANES  (MAX_VERTICES),
      .COLOR_W (COLOR_W),
      .NCOLORS (MAX_COLORS)
   ) u_merge (
      .used_in     (lane_used),
      .cur_in      (lane_cur),
      .color_limit (nc_sat),
      .found       (pick_found),
      .pick_color  (pick_color)
   );

   // Sequencer, config registers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         u_ff            <= '0;
         rsp_valid_ff    <= 1'b0;
         num_colors_ff   <= gmcs_pkg::NUM_COLORS_RST;
         num_vertices_ff <= gmcs_pkg::NUM_VERTICES_RST;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               gmcs_pkg::CSR_NUM_COLORS: begin
                  num_colors_ff <= csr_data[gmcs_pkg::NUM_COLORS_W-1:0];
               end
               gmcs_pkg::CSR_NUM_VERTICES: begin
                  num_vertices_ff <= csr_data;
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire && req_last_row) begin
                  u_ff     <= '0;
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               // all vertices colored: success
               if (u_ff >= nv_sat) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_colorable_ff <= 1'b1;
                  state_ff         <= S_IDLE;
               end else begin
                  state_ff <= S_LANE;
               end
            end
            S_LANE: begin
               state_ff <= S_PICK;
            end
            S_PICK: begin
               if (pick_found) begin
                  u_ff     <= VCNT_W'(u_ff + 1'b1);
                  state_ff <= S_FETCH;
               end else if (u_ff == '0) begin
                  // first vertex out of colors: no coloring exists
                  rsp_valid_ff     <= 1'b1;
                  rsp_colorable_ff <= 1'b0;
                  state_ff         <= S_IDLE;
               end else begin
                  u_ff     <= VCNT_W'(u_ff - 1'b1);
                  state_ff <= S_FETCH;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Checks
   `GMCS_ASSERT_IMP(a_pick_in_range, state_ff == S_PICK, u_ff < nv_sat,
                    "pick on vertex out of range")
   `GMCS_ASSERT_IMP(a_pick_color_ok, (state_ff == S_PICK) && pick_found,
                    (pick_color != '0) && (pick_color <= nc_sat), "picked color outside limit")
   `GMCS_ASSERT_NXT(a_search_start, req_fire && req_last_row,
                    (state_ff == S_FETCH) && (u_ff == '0), "search did not start at vertex zero")
   `GMCS_ASSERT_IMP(a_rsp_source, $rose(rsp_valid_ff),
                    ($past(state_ff) == S_FETCH) || ($past(state_ff) == S_PICK),
                    "result raised outside search end")

endmodule
